// ===== sv/tprt_pkg.sv =====
// shared types and constants for the tunnel peer table router
// no dependencies; used by the entry memory, the core and the testbench
package tprt_pkg;

    // command codes of an input beat
    localparam logic [2:0] CMD_REGISTER   = 3'd0;
    localparam logic [2:0] CMD_PEER_DATA  = 3'd1;
    localparam logic [2:0] CMD_KEEPALIVE  = 3'd2;
    localparam logic [2:0] CMD_DISCONNECT = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;
    localparam logic [2:0] CMD_LOCAL_DATA = 3'd5;

    // action codes of a result beat
    localparam logic [3:0] ACT_ASSIGN_NEW     = 4'd0;
    localparam logic [3:0] ACT_ASSIGN_REFRESH = 4'd1;
    localparam logic [3:0] ACT_TABLE_FULL     = 4'd2;
    localparam logic [3:0] ACT_POOL_EMPTY     = 4'd3;
    localparam logic [3:0] ACT_LOCAL          = 4'd4;
    localparam logic [3:0] ACT_FORWARD        = 4'd5;
    localparam logic [3:0] ACT_BCAST_LOCAL    = 4'd6;
    localparam logic [3:0] ACT_BCAST          = 4'd7;
    localparam logic [3:0] ACT_DROP           = 4'd8;
    localparam logic [3:0] ACT_PEER_LEFT      = 4'd9;
    localparam logic [3:0] ACT_KEEPALIVE_ACK  = 4'd10;
    localparam logic [3:0] ACT_IGNORED        = 4'd11;

    // configuration register indexes
    localparam logic [2:0] REG_POOL_FIRST = 3'd0;
    localparam logic [2:0] REG_POOL_LAST  = 3'd1;
    localparam logic [2:0] REG_SERVER_IP  = 3'd2;
    localparam logic [2:0] REG_BCAST_IP   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT    = 3'd4;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd30;
    localparam int unsigned MIN_PACKET_LEN = 20;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [15:0] packet_length;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  action;
        logic [3:0]  peer_index;
        logic [31:0] virtual_ip;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic        has_exclude;
        logic [3:0]  exclude_index;
        logic        last;
    } t_out_beat;

    // write strobes into the entry memory
    typedef struct packed {
        logic new_entry;
        logic refresh;
    } t_mem_we;

endpackage

// ===== sv/tprt_stream_if.sv =====
// valid/ready stream channel carrying one payload beat
// depends on nothing; payload type is set per instance
interface tprt_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/tprt_entry_mem.sv =====
// peer entry storage: virtual ip, real endpoint and last-seen time per slot
// depends on tprt_pkg; one write and one registered read per cycle
module tprt_entry_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  tprt_pkg::t_mem_we i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [31:0]      i_wr_vip,
    input  logic [31:0]      i_wr_addr_ip,
    input  logic [15:0]      i_wr_port,
    input  logic [31:0]      i_wr_last,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [31:0]      o_rd_vip,
    output logic [31:0]      o_rd_addr_ip,
    output logic [15:0]      o_rd_port,
    output logic [31:0]      o_rd_last
);
    logic [31:0] r_vip  [DEPTH];
    logic [31:0] r_addr [DEPTH];
    logic [15:0] r_port [DEPTH];
    logic [31:0] r_last [DEPTH];

    // writes: a new entry fills every field, a refresh only the time
    always_ff @(posedge i_clk) begin
        if (i_we.new_entry) begin
            r_vip[i_wr_addr]  <= i_wr_vip;
            r_addr[i_wr_addr] <= i_wr_addr_ip;
            r_port[i_wr_addr] <= i_wr_port;
        end
        if (i_we.new_entry || i_we.refresh) begin
            r_last[i_wr_addr] <= i_wr_last;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rd_vip     <= r_vip[i_rd_addr];
        o_rd_addr_ip <= r_addr[i_rd_addr];
        o_rd_port    <= r_port[i_rd_addr];
        o_rd_last    <= r_last[i_rd_addr];
    end
endmodule

// ===== sv/tunnel_peer_table_router_core.sv =====
// Peer table and route decision for a tunnel server. Every command walks the
// table once, one slot per cycle through the entry memory read port (a tick
// can hold the walk while the result port is busy); a register that allocates
// a new address then tries pool candidates in turn, and a tick
// waits on the result port when it expires more than one peer. The next item
// is taken only once the result, if any, is in the output register.
// depends on tprt_pkg, tprt_stream_if and tprt_entry_mem
module tunnel_peer_table_router_core #(
    parameter int MAX_PEERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tprt_stream_if.sink         i_in,
    tprt_stream_if.source       o_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int KW = $clog2(MAX_PEERS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PEERS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_ALLOC  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_TFIN   = 3'd5;

    // configuration registers
    logic [31:0] r_pool_first, r_pool_last, r_server_ip, r_bcast_ip;
    logic [15:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_first <= '0;
            r_pool_last  <= '0;
            r_server_ip  <= '0;
            r_bcast_ip   <= '0;
            r_timeout    <= tprt_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tprt_pkg::REG_POOL_FIRST: r_pool_first <= i_cfg_data;
                tprt_pkg::REG_POOL_LAST:  r_pool_last  <= i_cfg_data;
                tprt_pkg::REG_SERVER_IP:  r_server_ip  <= i_cfg_data;
                tprt_pkg::REG_BCAST_IP:   r_bcast_ip   <= i_cfg_data;
                tprt_pkg::REG_TIMEOUT:    r_timeout    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer and scan state
    logic [2:0]           r_state, n_state;
    logic [2:0]           r_cmd, n_cmd;
    logic [31:0]          r_src_addr, n_src_addr;
    logic [15:0]          r_src_port, n_src_port;
    logic [31:0]          r_dst, n_dst;
    logic                 r_short, n_short;
    logic [IW-1:0]        r_idx, n_idx;
    logic                 r_ep_hit, n_ep_hit;
    logic [IW-1:0]        r_ep_idx, n_ep_idx;
    logic [31:0]          r_ep_vip, n_ep_vip;
    logic                 r_vh, n_vh;
    logic [IW-1:0]        r_vh_idx, n_vh_idx;
    logic [31:0]          r_vh_addr, n_vh_addr;
    logic [15:0]          r_vh_port, n_vh_port;
    logic                 r_free_hit, n_free_hit;
    logic [IW-1:0]        r_free_idx, n_free_idx;
    logic [MAX_PEERS:0]   r_used, n_used;
    logic [KW-1:0]        r_k, n_k;
    logic [MAX_PEERS-1:0] r_active, n_active;
    logic [31:0]          r_now, n_now;
    logic                 r_out_v, n_out_v;
    tprt_pkg::t_out_beat  r_out, n_out;
    logic                 r_hold_v, n_hold_v;
    tprt_pkg::t_out_beat  r_hold, n_hold;
    tprt_pkg::t_out_beat  r_res, n_res;

    // entry memory
    tprt_pkg::t_mem_we mem_we;
    logic [IW-1:0]     mem_wr_addr;
    logic [31:0]       mem_wr_vip;
    logic [31:0]       rd_vip, rd_addr, rd_last;
    logic [15:0]       rd_port;

    tprt_entry_mem #(
        .DEPTH (MAX_PEERS),
        .AW    (IW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_we         (mem_we),
        .i_wr_addr    (mem_wr_addr),
        .i_wr_vip     (mem_wr_vip),
        .i_wr_addr_ip (r_src_addr),
        .i_wr_port    (r_src_port),
        .i_wr_last    (r_now),
        .i_rd_addr    (n_idx),
        .o_rd_vip     (rd_vip),
        .o_rd_addr_ip (rd_addr),
        .o_rd_port    (rd_port),
        .o_rd_last    (rd_last)
    );

    // result beat builder
    function automatic tprt_pkg::t_out_beat mk_beat(
        input logic [3:0]    act,
        input logic          has_slot,
        input logic [IW-1:0] slot,
        input logic [31:0]   vip,
        input logic [31:0]   addr,
        input logic [15:0]   port,
        input logic          hasx,
        input logic [IW-1:0] xslot
    );
        tprt_pkg::t_out_beat b;
        logic [IW+3:0]       es;
        logic [IW+3:0]       ex;
        es = {4'b0000, slot};
        ex = {4'b0000, xslot};
        b = '0;
        b.action = act;
        if (has_slot) begin
            b.peer_index = es[3:0];
            b.virtual_ip = vip;
            b.peer_addr  = addr;
            b.peer_port  = port;
        end
        if (hasx) begin
            b.has_exclude   = 1'b1;
            b.exclude_index = ex[3:0];
        end
        return b;
    endfunction

    logic          out_free;
    logic          cur_active;
    logic          ep_match, vh_match, expire, scan_go;
    logic [31:0]   pool_diff;
    logic [32:0]   cand;
    logic [IW-1:0] zi;

    assign out_free   = !r_out_v || o_out.ready;
    assign cur_active = r_active[r_idx];
    assign zi         = '0;
    assign pool_diff  = rd_vip - r_pool_first;
    assign cand       = {1'b0, r_pool_first} + {{(33-KW){1'b0}}, r_k};
    assign ep_match   = cur_active && rd_addr == r_src_addr && rd_port == r_src_port;
    assign vh_match   = cur_active && rd_vip == r_dst;
    assign expire     = cur_active && (r_now - rd_last) > {16'b0, r_timeout};
    // a tick that expires a second peer waits until the held beat can move
    assign scan_go    = !(r_cmd == tprt_pkg::CMD_TICK && expire && r_hold_v && !out_free);

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_v;
    assign o_out.payload = r_out;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_src_addr = r_src_addr;
        n_src_port = r_src_port;
        n_dst      = r_dst;
        n_short    = r_short;
        n_idx      = r_idx;
        n_ep_hit   = r_ep_hit;
        n_ep_idx   = r_ep_idx;
        n_ep_vip   = r_ep_vip;
        n_vh       = r_vh;
        n_vh_idx   = r_vh_idx;
        n_vh_addr  = r_vh_addr;
        n_vh_port  = r_vh_port;
        n_free_hit = r_free_hit;
        n_free_idx = r_free_idx;
        n_used     = r_used;
        n_k        = r_k;
        n_active   = r_active;
        n_now      = r_now;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        n_res      = r_res;
        n_out_v    = r_out_v;
        n_out      = r_out;
        mem_we      = '0;
        mem_wr_addr = r_ep_idx;
        mem_wr_vip  = cand[31:0];

        // output register drains
        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd      = i_in.payload.command;
                    n_src_addr = i_in.payload.src_addr;
                    n_src_port = i_in.payload.src_port;
                    n_dst      = i_in.payload.dst_ip;
                    n_short    = i_in.payload.packet_length
                                 < 16'(tprt_pkg::MIN_PACKET_LEN);
                    n_idx      = '0;
                    n_ep_hit   = 1'b0;
                    n_vh       = 1'b0;
                    n_free_hit = 1'b0;
                    n_used     = '0;
                    n_k        = '0;
                    n_hold_v   = 1'b0;
                    if (i_in.payload.command == tprt_pkg::CMD_TICK) begin
                        n_now = r_now + 32'd1;
                    end
                    n_state = S_SCAN;
                end
            end

            // one slot per cycle unless held: endpoint, vip, free, pool use, expiry
            S_SCAN: begin
                if (scan_go) begin
                    if (ep_match && !r_ep_hit) begin
                        n_ep_hit = 1'b1;
                        n_ep_idx = r_idx;
                        n_ep_vip = rd_vip;
                    end
                    if (vh_match && !r_vh) begin
                        n_vh      = 1'b1;
                        n_vh_idx  = r_idx;
                        n_vh_addr = rd_addr;
                        n_vh_port = rd_port;
                    end
                    if (!cur_active && !r_free_hit) begin
                        n_free_hit = 1'b1;
                        n_free_idx = r_idx;
                    end
                    if (cur_active && rd_vip >= r_pool_first
                        && pool_diff <= 32'(MAX_PEERS)) begin
                        n_used[pool_diff[KW-1:0]] = 1'b1;
                    end
                    if (r_cmd == tprt_pkg::CMD_TICK && expire) begin
                        n_active[r_idx] = 1'b0;
                        if (r_hold_v) begin
                            n_out_v = 1'b1;
                            n_out   = r_hold;
                        end
                        n_hold_v = 1'b1;
                        n_hold   = mk_beat(tprt_pkg::ACT_PEER_LEFT, 1'b1, r_idx,
                                           rd_vip, rd_addr, rd_port, 1'b0, zi);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = (r_cmd == tprt_pkg::CMD_TICK) ? S_TFIN : S_DECIDE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end

            // route and table decision from the scan records
            S_DECIDE: begin
                n_state = S_EMIT;
                n_res   = mk_beat(tprt_pkg::ACT_IGNORED, 1'b0, zi, '0, '0, '0, 1'b0, zi);
                case (r_cmd)
                    tprt_pkg::CMD_REGISTER: begin
                        if (r_ep_hit) begin
                            mem_we.refresh = 1'b1;
                            n_res = mk_beat(tprt_pkg::ACT_ASSIGN_REFRESH, 1'b1, r_ep_idx,
                                            r_ep_vip, r_src_addr, r_src_port, 1'b0, zi);
                        end else if (!r_free_hit) begin
                            n_res = mk_beat(tprt_pkg::ACT_TABLE_FULL, 1'b0, zi,
                                            '0, '0, '0, 1'b0, zi);
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end
                    tprt_pkg::CMD_PEER_DATA: begin
                        if (r_short || r_dst == '0 || !r_ep_hit) begin
                            n_res = mk_beat(tprt_pkg::ACT_DROP, 1'b0, zi,
                                            '0, '0, '0, 1'b0, zi);
                        end else if (r_dst == r_server_ip) begin
                            n_res = mk_beat(tprt_pkg::ACT_LOCAL, 1'b0, zi,
                                            '0, '0, '0, 1'b0, zi);
                        end else if (r_dst == r_bcast_ip) begin
                            n_res = mk_beat(tprt_pkg::ACT_BCAST_LOCAL, 1'b0, zi,
                                            '0, '0, '0, 1'b1, r_ep_idx);
                        end else if (r_vh) begin
                            n_res = mk_beat(tprt_pkg::ACT_FORWARD, 1'b1, r_vh_idx,
                                            r_dst, r_vh_addr, r_vh_port, 1'b0, zi);
                        end else begin
                            n_res = mk_beat(tprt_pkg::ACT_DROP, 1'b0, zi,
                                            '0, '0, '0, 1'b0, zi);
                        end
                    end
                    tprt_pkg::CMD_KEEPALIVE: begin
                        if (r_ep_hit) begin
                            mem_we.refresh = 1'b1;
                            n_res = mk_beat(tprt_pkg::ACT_KEEPALIVE_ACK, 1'b1, r_ep_idx,
                                            r_ep_vip, r_src_addr, r_src_port, 1'b0, zi);
                        end
                    end
                    tprt_pkg::CMD_DISCONNECT: begin
                        if (r_ep_hit) begin
                            n_active[r_ep_idx] = 1'b0;
                            n_res = mk_beat(tprt_pkg::ACT_PEER_LEFT, 1'b1, r_ep_idx,
                                            r_ep_vip, r_src_addr, r_src_port, 1'b0, zi);
                        end
                    end
                    tprt_pkg::CMD_LOCAL_DATA: begin
                        if (r_dst == '0) begin
                            n_res = mk_beat(tprt_pkg::ACT_DROP, 1'b0, zi,
                                            '0, '0, '0, 1'b0, zi);
                        end else if (r_dst == r_bcast_ip) begin
                            n_res = mk_beat(tprt_pkg::ACT_BCAST, 1'b0, zi,
                                            '0, '0, '0, 1'b0, zi);
                        end else if (r_vh) begin
                            n_res = mk_beat(tprt_pkg::ACT_FORWARD, 1'b1, r_vh_idx,
                                            r_dst, r_vh_addr, r_vh_port, 1'b0, zi);
                        end else begin
                            n_res = mk_beat(tprt_pkg::ACT_DROP, 1'b0, zi,
                                            '0, '0, '0, 1'b0, zi);
                        end
                    end
                    default: ;
                endcase
            end

            // lowest pool address not in use, one candidate per cycle
            S_ALLOC: begin
                if (cand > {1'b0, r_pool_last}) begin
                    n_res   = mk_beat(tprt_pkg::ACT_POOL_EMPTY, 1'b0, zi,
                                      '0, '0, '0, 1'b0, zi);
                    n_state = S_EMIT;
                end else if (!r_used[r_k]) begin
                    mem_we.new_entry = 1'b1;
                    mem_wr_addr      = r_free_idx;
                    n_active[r_free_idx] = 1'b1;
                    n_res   = mk_beat(tprt_pkg::ACT_ASSIGN_NEW, 1'b1, r_free_idx,
                                      cand[31:0], r_src_addr, r_src_port, 1'b0, zi);
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end

            // single result beat, always the final one
            S_EMIT: begin
                if (out_free) begin
                    n_out_v   = 1'b1;
                    n_out     = r_res;
                    n_out.last = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // tick end: the held beat becomes the final one
            S_TFIN: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_hold;
                    n_out.last = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_now    <= '0;
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_now    <= n_now;
            r_out_v  <= n_out_v;
            r_hold_v <= n_hold_v;
        end
    end

    // payload and scan records
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_src_addr <= n_src_addr;
        r_src_port <= n_src_port;
        r_dst      <= n_dst;
        r_short    <= n_short;
        r_idx      <= n_idx;
        r_ep_hit   <= n_ep_hit;
        r_ep_idx   <= n_ep_idx;
        r_ep_vip   <= n_ep_vip;
        r_vh       <= n_vh;
        r_vh_idx   <= n_vh_idx;
        r_vh_addr  <= n_vh_addr;
        r_vh_port  <= n_vh_port;
        r_free_hit <= n_free_hit;
        r_free_idx <= n_free_idx;
        r_used     <= n_used;
        r_k        <= n_k;
        r_hold     <= n_hold;
        r_res      <= n_res;
        r_out      <= n_out;
    end
endmodule

// ===== sim/tb_tunnel_peer_table_router_core.sv =====
// testbench for the tunnel peer table router core: directed and random commands
// checked beat by beat against an in-bench peer table predictor
// depends on tprt_pkg, tprt_stream_if and tunnel_peer_table_router_core
module tb_tunnel_peer_table_router_core;

    localparam int N_PEERS = 16;

    // peer table predictor and queue of expected result beats
    class route_scoreboard;
        logic [31:0] pool_lo, pool_hi, srv_ip, bc_ip;
        logic [15:0] idle_limit;
        bit          live [N_PEERS];
        logic [31:0] vip [N_PEERS];
        logic [31:0] raddr [N_PEERS];
        logic [15:0] rport [N_PEERS];
        logic [31:0] seen [N_PEERS];
        logic [31:0] now_sec;
        tprt_pkg::t_out_beat pending [$];
        int          errors;

        function new();
            pool_lo = 0; pool_hi = 0; srv_ip = 0; bc_ip = 0;
            idle_limit = tprt_pkg::TIMEOUT_RESET; now_sec = 0; errors = 0;
            foreach (live[i]) begin
                live[i] = 0; vip[i] = 0; raddr[i] = 0; rport[i] = 0; seen[i] = 0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                tprt_pkg::REG_POOL_FIRST: pool_lo = val;
                tprt_pkg::REG_POOL_LAST:  pool_hi = val;
                tprt_pkg::REG_SERVER_IP:  srv_ip = val;
                tprt_pkg::REG_BCAST_IP:   bc_ip = val;
                tprt_pkg::REG_TIMEOUT:    idle_limit = val[15:0];
                default: ;
            endcase
        endfunction

        function int by_endpoint(logic [31:0] a, logic [15:0] p);
            for (int i = 0; i < N_PEERS; i++)
                if (live[i] && raddr[i] == a && rport[i] == p) return i;
            return -1;
        endfunction

        function int by_vip(logic [31:0] v);
            for (int i = 0; i < N_PEERS; i++)
                if (live[i] && vip[i] == v) return i;
            return -1;
        endfunction

        function void push(logic [3:0] act, int slot, int xslot);
            tprt_pkg::t_out_beat b;
            b = '0;
            b.action = act;
            if (slot >= 0) begin
                b.peer_index = slot[3:0]; b.virtual_ip = vip[slot];
                b.peer_addr = raddr[slot]; b.peer_port = rport[slot];
            end
            if (xslot >= 0) begin
                b.has_exclude = 1'b1; b.exclude_index = xslot[3:0];
            end
            pending.push_back(b);
        endfunction

        // note an accepted input beat and queue its results
        function void note_input(tprt_pkg::t_in_beat t);
            int s, f, n0;
            bit got;
            logic [32:0] c;
            n0 = pending.size();
            case (t.command)
                tprt_pkg::CMD_REGISTER: begin
                    s = by_endpoint(t.src_addr, t.src_port);
                    if (s >= 0) begin
                        seen[s] = now_sec; push(tprt_pkg::ACT_ASSIGN_REFRESH, s, -1);
                    end else begin
                        f = -1;
                        for (int i = N_PEERS - 1; i >= 0; i--) if (!live[i]) f = i;
                        if (f < 0) push(tprt_pkg::ACT_TABLE_FULL, -1, -1);
                        else begin
                            got = 0; c = {1'b0, pool_lo};
                            for (int k = 0; k <= N_PEERS; k++, c++) begin
                                if (c > {1'b0, pool_hi}) break;
                                if (by_vip(c[31:0]) < 0) begin
                                    got = 1;
                                    break;
                                end
                            end
                            if (!got) push(tprt_pkg::ACT_POOL_EMPTY, -1, -1);
                            else begin
                                live[f] = 1; vip[f] = c[31:0];
                                raddr[f] = t.src_addr; rport[f] = t.src_port;
                                seen[f] = now_sec; push(tprt_pkg::ACT_ASSIGN_NEW, f, -1);
                            end
                        end
                    end
                end
                tprt_pkg::CMD_PEER_DATA: begin
                    s = by_endpoint(t.src_addr, t.src_port);
                    if (t.packet_length < tprt_pkg::MIN_PACKET_LEN || t.dst_ip == 0 || s < 0)
                        push(tprt_pkg::ACT_DROP, -1, -1);
                    else if (t.dst_ip == srv_ip) push(tprt_pkg::ACT_LOCAL, -1, -1);
                    else if (t.dst_ip == bc_ip) push(tprt_pkg::ACT_BCAST_LOCAL, -1, s);
                    else begin
                        f = by_vip(t.dst_ip);
                        if (f < 0) push(tprt_pkg::ACT_DROP, -1, -1);
                        else push(tprt_pkg::ACT_FORWARD, f, -1);
                    end
                end
                tprt_pkg::CMD_KEEPALIVE, tprt_pkg::CMD_DISCONNECT: begin
                    s = by_endpoint(t.src_addr, t.src_port);
                    if (s < 0) push(tprt_pkg::ACT_IGNORED, -1, -1);
                    else if (t.command == tprt_pkg::CMD_KEEPALIVE) begin
                        seen[s] = now_sec; push(tprt_pkg::ACT_KEEPALIVE_ACK, s, -1);
                    end else begin
                        live[s] = 0; push(tprt_pkg::ACT_PEER_LEFT, s, -1);
                    end
                end
                tprt_pkg::CMD_TICK: begin
                    now_sec++;
                    for (int i = 0; i < N_PEERS; i++)
                        if (live[i] && (now_sec - seen[i]) > {16'd0, idle_limit}) begin
                            live[i] = 0; push(tprt_pkg::ACT_PEER_LEFT, i, -1);
                        end
                end
                tprt_pkg::CMD_LOCAL_DATA: begin
                    if (t.dst_ip == 0) push(tprt_pkg::ACT_DROP, -1, -1);
                    else if (t.dst_ip == bc_ip) push(tprt_pkg::ACT_BCAST, -1, -1);
                    else begin
                        f = by_vip(t.dst_ip);
                        if (f < 0) push(tprt_pkg::ACT_DROP, -1, -1);
                        else push(tprt_pkg::ACT_FORWARD, f, -1);
                    end
                end
                default: push(tprt_pkg::ACT_IGNORED, -1, -1);
            endcase
            if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(tprt_pkg::t_out_beat r);
            tprt_pkg::t_out_beat e;
            if (pending.size() == 0) begin
                $error("unexpected result beat action=%0d", r.action);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.action !== e.action) begin
                $error("action exp %0d got %0d", e.action, r.action); errors++;
            end
            if (r.peer_index !== e.peer_index) begin
                $error("peer_index exp %0d got %0d", e.peer_index, r.peer_index); errors++;
            end
            if (r.virtual_ip !== e.virtual_ip) begin
                $error("virtual_ip exp %h got %h", e.virtual_ip, r.virtual_ip); errors++;
            end
            if (r.peer_addr !== e.peer_addr) begin
                $error("peer_addr exp %h got %h", e.peer_addr, r.peer_addr); errors++;
            end
            if (r.peer_port !== e.peer_port) begin
                $error("peer_port exp %h got %h", e.peer_port, r.peer_port); errors++;
            end
            if (r.has_exclude !== e.has_exclude) begin
                $error("has_exclude exp %0d got %0d", e.has_exclude, r.has_exclude); errors++;
            end
            if (r.exclude_index !== e.exclude_index) begin
                $error("exclude_index exp %0d got %0d", e.exclude_index, r.exclude_index);
                errors++;
            end
            if (r.last !== e.last) begin
                $error("last exp %0d got %0d", e.last, r.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    tprt_stream_if #(.t_payload(tprt_pkg::t_in_beat))  cmd_ch ();
    tprt_stream_if #(.t_payload(tprt_pkg::t_out_beat)) res_ch ();

    tunnel_peer_table_router_core #(.MAX_PEERS(N_PEERS)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_ch.sink),
        .o_out       (res_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    route_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  quiet_cycles = 0;
    // small sets of endpoints and addresses so lookups hit often
    logic [31:0] ep_addr [4] = '{32'h0A000001, 32'hC0A80102, 32'hFFFFFFFF, 32'h00000000};
    logic [15:0] ep_port [4] = '{16'd5000, 16'd51820, 16'hFFFF, 16'd0};

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready = 1'b0;
    end

    // result side: random stalls, checking at accepted beats
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
        res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("[tunnel_peer_table_router_core] ERROR");
            $finish;
        end
    end

    // valid stays up after a beat so the next one can follow at once
    task automatic send_beat(tprt_pkg::t_in_beat t);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= t;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.note_input(t);
    endtask

    task automatic send_cmd(logic [2:0] c, int ep, logic [31:0] dst, logic [15:0] len);
        tprt_pkg::t_in_beat t;
        t.command = c;
        t.src_addr = ep_addr[ep];
        t.src_port = ep_port[ep];
        t.dst_ip = dst;
        t.packet_length = len;
        send_beat(t);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_table(logic [31:0] lo, logic [31:0] hi, logic [31:0] srv,
                             logic [31:0] bc, logic [15:0] tmo);
        drain();
        write_reg(tprt_pkg::REG_POOL_FIRST, lo);
        write_reg(tprt_pkg::REG_POOL_LAST, hi);
        write_reg(tprt_pkg::REG_SERVER_IP, srv);
        write_reg(tprt_pkg::REG_BCAST_IP, bc);
        write_reg(tprt_pkg::REG_TIMEOUT, {16'd0, tmo});
    endtask

    // random beat, mostly from known endpoints, half toward addresses at the pool start
    task automatic send_random();
        tprt_pkg::t_in_beat t;
        int r;
        r = $urandom_range(99);
        t.command = (r < 25) ? tprt_pkg::CMD_REGISTER : (r < 50) ? tprt_pkg::CMD_PEER_DATA :
                    (r < 60) ? tprt_pkg::CMD_KEEPALIVE : (r < 68) ? tprt_pkg::CMD_DISCONNECT :
                    (r < 80) ? tprt_pkg::CMD_TICK : (r < 95) ? tprt_pkg::CMD_LOCAL_DATA :
                    3'($urandom_range(7));
        if ($urandom_range(9) == 0) begin
            t.src_addr = $urandom; t.src_port = 16'($urandom);
        end else begin
            r = $urandom_range(3);
            t.src_addr = ep_addr[r];
            t.src_port = ($urandom_range(7) == 0) ? ep_port[(r + 1) % 4] : ep_port[r];
        end
        r = $urandom_range(9);
        t.dst_ip = (r < 5) ? sb.pool_lo + 32'($urandom_range(5)) :
                   (r == 5) ? sb.srv_ip : (r == 6) ? sb.bc_ip : (r == 7) ? 32'd0 : $urandom;
        t.packet_length = ($urandom_range(3) == 0) ? 16'($urandom_range(21, 18))
                                                   : 16'($urandom);
        send_beat(t);
    endtask

    initial begin
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pool at the top of the space, tiny timeout
        set_table(32'hFFFFFFFE, 32'hFFFFFFFF, 32'h0A090001, 32'h0A0900FF, 16'd1);
        send_cmd(tprt_pkg::CMD_REGISTER, 0, 0, 0);
        send_cmd(tprt_pkg::CMD_REGISTER, 1, 0, 0);
        send_cmd(tprt_pkg::CMD_REGISTER, 2, 0, 0);          // pool exhausted
        send_cmd(tprt_pkg::CMD_REGISTER, 0, 0, 0);          // refresh
        send_cmd(tprt_pkg::CMD_PEER_DATA, 0, 32'hFFFFFFFF, 16'd20);
        send_cmd(tprt_pkg::CMD_PEER_DATA, 0, 32'hFFFFFFFF, 16'd19); // short
        send_cmd(tprt_pkg::CMD_PEER_DATA, 0, 32'd0, 16'hFFFF);      // no destination
        send_cmd(tprt_pkg::CMD_PEER_DATA, 2, 32'hFFFFFFFE, 16'd40); // unknown sender
        send_cmd(tprt_pkg::CMD_PEER_DATA, 1, 32'h0A090001, 16'd40); // local
        send_cmd(tprt_pkg::CMD_PEER_DATA, 1, 32'h0A0900FF, 16'd40); // broadcast with exclude
        send_cmd(tprt_pkg::CMD_LOCAL_DATA, 2, 32'h0A0900FF, 0);
        send_cmd(tprt_pkg::CMD_LOCAL_DATA, 2, 32'hFFFFFFFE, 0);
        send_cmd(tprt_pkg::CMD_LOCAL_DATA, 2, 32'h12345678, 0);
        send_cmd(tprt_pkg::CMD_LOCAL_DATA, 2, 32'd0, 0);
        send_cmd(tprt_pkg::CMD_KEEPALIVE, 1, 0, 0);
        send_cmd(tprt_pkg::CMD_KEEPALIVE, 3, 0, 0);         // unknown
        send_cmd(tprt_pkg::CMD_DISCONNECT, 3, 0, 0);        // unknown
        send_cmd(tprt_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(tprt_pkg::CMD_TICK, 0, 0, 0);
        send_cmd(tprt_pkg::CMD_TICK, 0, 0, 0);              // no peer left to expire
        send_cmd(3'd6, 0, 0, 0);
        send_cmd(3'd7, 0, 0, 0);
        // inverted pool, then address zero in the pool
        set_table(32'd5, 32'd4, 32'd0, 32'd0, 16'hFFFF);
        send_cmd(tprt_pkg::CMD_REGISTER, 0, 0, 0);
        set_table(32'd0, 32'd100, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        for (int i = 0; i < 17; i++) begin        // fill the table, then full
            tprt_pkg::t_in_beat t;
            t.command = tprt_pkg::CMD_REGISTER; t.src_addr = 32'h0B000000 + i;
            t.src_port = 16'(i); t.dst_ip = 0; t.packet_length = 0;
            send_beat(t);
        end
        set_table(32'd0, 32'd100, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd0);
        send_cmd(tprt_pkg::CMD_TICK, 0, 0, 0);              // sixteen peers leave

        // back-pressure: receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            repeat (6) send_random();
        join

        // random phases across idle profiles and settings
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (phase == 4)
                set_table(32'hFFFFFFF8, 32'hFFFFFFFC, 32'hFFFFFFFD, 32'hFFFFFFFF, 16'd3);
            else if (phase == 6)
                set_table(32'h0A090002, 32'h0A090004, 32'h0A090001, 32'h0A0900FF, 16'd6);
            else if (phase == 0)
                set_table(32'h0A090002, 32'h0A0900FE, 32'h0A090001, 32'h0A0900FF, 16'd5);
            repeat (25) send_random();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[tunnel_peer_table_router_core] OK");
        else
            $display("[tunnel_peer_table_router_core] ERROR");
        $finish;
    end

endmodule
